/* rtl/gnb_pkg.sv */
// Package for the grid next-boundary block: field widths, register indexes,
// division codes and reset values. No dependencies.
`default_nettype none

package gnb_pkg;

    // Channel field widths
    localparam int C_POS_W  = 54;
    localparam int C_FUNC_W = 3;
    localparam int C_BND_W  = 53;

    // Configuration port
    localparam int C_CFG_W  = 19;
    localparam int C_IDX_W  = 2;

    localparam logic [C_IDX_W-1:0] C_REG_SAMPLE_RATE = 2'd0;
    localparam logic [C_IDX_W-1:0] C_REG_TEMPO       = 2'd1;
    localparam logic [C_IDX_W-1:0] C_REG_SIG_NUM     = 2'd2;
    localparam logic [C_IDX_W-1:0] C_REG_SIG_DEN     = 2'd3;

    // Register widths
    localparam int C_SR_W    = 19;
    localparam int C_TEMPO_W = 18;
    localparam int C_SIG_W   = 6;

    // Seconds per minute times the tempo fraction scale
    localparam int C_SR_SCALE = 60 * 256;
    localparam int C_SRS_W    = 33;
    // Rate * scale * beat-unit count
    localparam int C_X_W      = C_SRS_W + C_SIG_W;
    // Tempo shifted by the note division (up to 16)
    localparam int C_D1_W     = C_TEMPO_W + 4;

    localparam logic [C_SR_W-1:0]    C_SR_RST    = 19'd48000;
    localparam logic [C_SRS_W-1:0]   C_SRS_RST   = 33'd737280000;
    localparam logic [C_TEMPO_W-1:0] C_TEMPO_RST = 18'd30720;
    localparam logic [C_SIG_W-1:0]   C_NUM_RST   = 6'd4;
    localparam logic [C_SIG_W-1:0]   C_DEN_RST   = 6'd4;

    // Division codes; all others mean off
    localparam logic [C_FUNC_W-1:0] C_FN_BAR       = 3'd1;
    localparam logic [C_FUNC_W-1:0] C_FN_HALF      = 3'd2;
    localparam logic [C_FUNC_W-1:0] C_FN_QUARTER   = 3'd3;
    localparam logic [C_FUNC_W-1:0] C_FN_EIGHTH    = 3'd4;
    localparam logic [C_FUNC_W-1:0] C_FN_SIXTEENTH = 3'd5;

endpackage

`default_nettype wire

/* rtl/gnb_in_if.sv */
// Input channel of the grid next-boundary block: position and division.
// Depends on gnb_pkg.
`default_nettype none

interface gnb_in_if
    import gnb_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [C_POS_W-1:0] pos;
    logic [C_FUNC_W-1:0]       func;

    modport source (output valid, output pos, output func, input ready);
    modport sink   (input valid, input pos, input func, output ready);
endinterface

`default_nettype wire

/* rtl/gnb_out_if.sv */
// Result channel of the grid next-boundary block: boundary and its flag.
// Depends on gnb_pkg.
`default_nettype none

interface gnb_out_if
    import gnb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [C_BND_W-1:0] boundary;
    logic               valid_res;

    modport source (output valid, output boundary, output valid_res, input ready);
    modport sink   (input valid, input boundary, input valid_res, output ready);
endinterface

`default_nettype wire

/* rtl/grid_next_boundary.sv */
// Channel    | Dir | Payload                 | Transfer when
// i_in       | in  | pos[53:0], func[2:0]    | valid & ready
// o_out      | out | boundary[52:0], flag    | valid & ready
// i_cfg_*    | in  | idx[1:0], data[18:0]    | i_cfg_we
//
// One item at a time. A valid item is decoded, then the serial divider runs twice (first the
// interval, then the grid index) and the serial multiplier forms the boundary, which is
// registered before it moves to the output register. An item rejected at decode goes straight
// to that last step, and one with a zero interval skips the second division and the multiply;
// the input reopens once the result is in the output register.
// Reset is synchronous and returns control state and the configuration to defaults.
// A stalled result waits in the output register; the next item is taken meanwhile.
// Depends on gnb_pkg, gnb_in_if, gnb_out_if, gnb_div and gnb_mul.
`default_nettype none

module grid_next_boundary
    import gnb_pkg::*;
#(
    parameter int POS_LIMIT_BITS = 52,
    parameter int FRAC_BITS      = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [C_IDX_W-1:0] i_cfg_idx,
    input  logic [C_CFG_W-1:0] i_cfg_data,
    gnb_in_if.sink             i_in,
    gnb_out_if.source          o_out
);

    localparam int IQ_W = C_X_W + FRAC_BITS;
    localparam int KW   = POS_LIMIT_BITS + FRAC_BITS;
    localparam int DW   = (IQ_W > KW) ? IQ_W : KW;
    localparam int B_W  = IQ_W + POS_LIMIT_BITS;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV1 = 5'b00010,
        ST_DIV2 = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    // Configuration
    logic [C_SRS_W-1:0]   r_srs;
    logic [C_TEMPO_W-1:0] r_tempo;
    logic [C_SIG_W-1:0]   r_num;
    logic [C_SIG_W-1:0]   r_den;

    // Sequencer and result
    t_state             r_state, n_state;
    logic [KW-1:0]      r_t, n_t;
    logic [IQ_W-1:0]    r_iq, n_iq;
    logic [C_BND_W-1:0] r_rb, n_rb;
    logic               r_rv, n_rv;
    logic               r_ov, n_ov;
    logic [C_BND_W-1:0] r_ob, n_ob;
    logic               r_ovr, n_ovr;

    // Item decode
    logic [C_SIG_W-1:0] w_mult;
    logic [2:0]         w_sh;
    logic               w_fn_ok;
    logic [C_BND_W-1:0] w_posu;
    logic               w_pos_big;
    logic               w_bad;
    logic [C_X_W-1:0]   w_x;
    logic [C_D1_W-1:0]  w_d1;
    logic [KW-1:0]      w_t;

    // Arithmetic units
    logic               div_start;
    logic [DW-1:0]      div_dvd;
    logic [IQ_W-1:0]    div_dvs;
    logic               div_done;
    logic [DW-1:0]      div_quo;
    logic [IQ_W-1:0]    div_rem;
    logic [IQ_W-1:0]    w_iq;
    logic [KW-1:0]      w_k;
    logic               mul_start;
    logic               mul_done;
    logic [IQ_W-1:0]    mul_hi;
    logic [KW-1:0]      mul_lo;
    logic [B_W-1:0]     w_b;
    logic               w_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srs   <= C_SRS_RST;
            r_tempo <= C_TEMPO_RST;
            r_num   <= C_NUM_RST;
            r_den   <= C_DEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_SAMPLE_RATE: r_srs <= C_SRS_W'(i_cfg_data[C_SR_W-1:0])
                                            * C_SRS_W'(C_SR_SCALE);
                C_REG_TEMPO:       r_tempo <= i_cfg_data[C_TEMPO_W-1:0];
                C_REG_SIG_NUM:     r_num <= i_cfg_data[C_SIG_W-1:0];
                C_REG_SIG_DEN:     r_den <= i_cfg_data[C_SIG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_mult  = r_den;
        w_sh    = 3'd0;
        w_fn_ok = 1'b1;
        case (i_in.func)
            C_FN_BAR:       w_mult = r_num;
            C_FN_HALF:      w_sh = 3'd1;
            C_FN_QUARTER:   w_sh = 3'd2;
            C_FN_EIGHTH:    w_sh = 3'd3;
            C_FN_SIXTEENTH: w_sh = 3'd4;
            default:        w_fn_ok = 1'b0;
        endcase
    end

    assign w_posu    = i_in.pos[C_BND_W-1:0];
    assign w_pos_big = (w_posu >> POS_LIMIT_BITS) != '0;
    assign w_bad     = (r_srs == '0) || (r_tempo == '0) || (r_den == '0) || !w_fn_ok
                       || (w_mult == '0) || i_in.pos[C_POS_W-1] || w_pos_big;
    assign w_x       = C_X_W'(r_srs) * C_X_W'(w_mult);
    assign w_d1      = C_D1_W'(r_tempo) << w_sh;
    // Position in fixed point plus half a frame
    assign w_t       = (KW'(w_posu) << FRAC_BITS) | (KW'(1) << (FRAC_BITS - 1));

    // First pass takes the interval, second pass the grid index
    assign div_dvd = (r_state == ST_IDLE) ? (DW'(w_x) << FRAC_BITS) : DW'(r_t);
    assign div_dvs = (r_state == ST_IDLE) ? IQ_W'(w_d1) : w_iq;
    assign w_iq    = div_quo[IQ_W-1:0];
    // Round the index up when the division leaves a remainder
    assign w_k     = div_quo[KW-1:0] + KW'(div_rem != '0);

    gnb_div #(
        .DW (DW),
        .VW (IQ_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    gnb_mul #(
        .AW      (KW),
        .BW      (IQ_W),
        .RND_BIT (FRAC_BITS - 1)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (w_k),
        .i_b     (r_iq),
        .o_done  (mul_done),
        .o_hi    (mul_hi),
        .o_lo    (mul_lo)
    );

    assign w_b   = {mul_hi, mul_lo[KW-1:FRAC_BITS]};
    assign w_fit = (w_b >> C_BND_W) == '0;

    always_comb begin
        n_state   = r_state;
        n_t       = r_t;
        n_iq      = r_iq;
        n_rb      = r_rb;
        n_rv      = r_rv;
        n_ov      = r_ov;
        n_ob      = r_ob;
        n_ovr     = r_ovr;
        div_start = 1'b0;
        mul_start = 1'b0;
        // drop the held result once transferred
        if (o_out.ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_t = w_t;
                    if (w_bad) begin
                        n_rb    = '0;
                        n_rv    = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    n_iq = w_iq;
                    if (w_iq == '0) begin
                        n_rb    = '0;
                        n_rv    = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV2;
                    end
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_rb    = w_fit ? w_b[C_BND_W-1:0] : '0;
                    n_rv    = w_fit;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_ob    = r_rb;
                    n_ovr   = r_rv;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_t   <= n_t;
        r_iq  <= n_iq;
        r_rb  <= n_rb;
        r_rv  <= n_rv;
        r_ob  <= n_ob;
        r_ovr <= n_ovr;
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.boundary  = r_ob;
    assign o_out.valid_res = r_ovr;

endmodule

`default_nettype wire

/* rtl/gnb_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used twice in turn by grid_next_boundary.
`default_nettype none

module gnb_div #(
    parameter int DW = 84,
    parameter int VW = 71
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dvd,
    input  logic [VW-1:0] i_dvs,
    output logic          o_done,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;
    logic          w_ge;

    // Dividend leaves from the top while quotient bits enter at the bottom
    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
                r_q   <= i_dvd;
                r_rem <= '0;
                r_dvs <= i_dvs;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_q   <= {r_q[DW-2:0], w_ge};
                r_rem <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/gnb_mul.sv */
// Bit-serial shift-add multiplier, LSB of the multiplier first, with a
// rounding constant preloaded into the accumulator. Standalone.
`default_nettype none

module gnb_mul #(
    parameter int AW      = 84,
    parameter int BW      = 71,
    parameter int RND_BIT = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic          o_done,
    output logic [BW-1:0] o_hi,
    output logic [AW-1:0] o_lo
);

    localparam int CW = $clog2(AW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [BW-1:0] r_acc;
    logic [AW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [BW:0]   w_sum;

    // Accumulator never exceeds the larger of the preload and the multiplicand
    assign w_sum = {1'b0, r_acc} + (r_a[0] ? {1'b0, r_b} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(AW);
                r_acc <= BW'(1) << RND_BIT;
                r_a   <= i_a;
                r_b   <= i_b;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_acc <= w_sum[BW:1];
                // product bits retire into the multiplier register from the top
                r_a   <= {w_sum[0], r_a[AW-1:1]};
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_hi   = r_acc;
    assign o_lo   = r_a;

endmodule

`default_nettype wire

/* rtl/gnb_chk.sv */
// Port checker for grid_next_boundary and the bind that attaches it.
// Depends on gnb_pkg.
`default_nettype none

module gnb_chk
    import gnb_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [C_BND_W-1:0] i_boundary,
    input wire logic               i_valid_res
);

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_boundary) && $stable(i_valid_res))
        else $error("stalled result changed");

    // Invalid result carries a zero boundary
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_valid_res |-> i_boundary == '0)
        else $error("invalid result with nonzero boundary");

    // A found boundary lies after a non-negative position, so never zero
    a_bnd_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_valid_res |-> i_boundary != '0)
        else $error("valid result with zero boundary");

    // One item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready straight after transfer");

endmodule

bind grid_next_boundary gnb_chk u_gnb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_boundary  (o_out.boundary),
    .i_valid_res (o_out.valid_res)
);

`default_nettype wire
